@@ hdl/wcd_pkg.sv @@
`default_nettype none
package wcd_pkg;

  localparam int FracBitsDef = 16;
  localparam int DvdW        = 64;
  localparam int DvsW        = 33;
  localparam int CfgIdxW     = 3;
  localparam logic [19:0] UsPerS = 20'd1000000;

  typedef enum logic [2:0] {
    CFG_CUTOFF    = 3'd0,
    CFG_MIN_ACCEL = 3'd1,
    CFG_MIN_TRQ   = 3'd2,
    CFG_LIFTOFF   = 3'd3,
    CFG_TOUCHDOWN = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLT_GO,
    S_FLT_DIV,
    S_ACC_GO,
    S_ACC_DIV,
    S_GATE,
    S_INR_GO,
    S_INR_DIV,
    S_OUT
  } state_e;

  // 1e-4 on the fixed-point grid, at least one LSB
  function automatic int eps_q(int frac_bits);
    int e;
    e = ((1 << frac_bits) + 5000) / 10000;
    return (e == 0) ? 1 : e;
  endfunction

endpackage
`default_nettype wire

@@ hdl/wcd_if.sv @@
`default_nettype none
interface wcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque_sample;
  logic signed [31:0] velocity_sample;
  logic        [15:0] step_us;
  modport source (output valid, torque_sample, velocity_sample, step_us, input ready);
  modport sink   (input valid, torque_sample, velocity_sample, step_us, output ready);
endinterface

interface wcd_out_if;
  logic        valid;
  logic        ready;
  logic        contact_out;
  logic [31:0] inertia_out;
  logic        not_configured;
  modport source (output valid, contact_out, inertia_out, not_configured, input ready);
  modport sink   (input valid, contact_out, inertia_out, not_configured, output ready);
endinterface
`default_nettype wire

@@ hdl/wcd_div.sv @@
`default_nettype none
module wcd_div import wcd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DvdW-1:0] quot_o
);
  localparam int CntW = $clog2(DvdW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   rem_sh, rem_sub;
  logic            ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DvdW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  assign done_o = busy_q && (cnt_q == CntW'(DvdW - 1));
  assign quot_o = {quo_q[DvdW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], ge};
      rem_q <= rem_sub[DvsW-1:0];
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider still busy after done");
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("divide by zero");

endmodule
`default_nettype wire

@@ hdl/wheel_contact_detector.sv @@
`default_nettype none
// channel | dir | payload
// in_i    | in  | torque_sample, velocity_sample, step_us
// out_o   | out | contact_out, inertia_out, not_configured
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
// One item at a time through one shared 64-step restoring divider.
// Configured item: up to 5 divisions plus control states;
// fewer divisions when step_us >= cutoff or touchdown is gated.
// Unconfigured item: result presented in the cycle after transfer.
// Async active-low reset clears FSM, config, result regs; output holds while stalled.
module wheel_contact_detector import wcd_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  wcd_in_if.sink            in_i,
  wcd_out_if.source         out_o,
  input  wire logic         cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  localparam logic [DvsW-1:0] EpsQ = DvsW'(eps_q(FracBits));

  state_e state_q, state_d;

  logic [23:0] cut_q;
  logic [31:0] min_acc_q, min_trq_q, lift_q, td_q;

  logic [31:0] fv_q, fv_d, maa_q, maa_d, mat_q, mat_d, inr_q, inr_d;
  logic        cont_q, cont_d, nc_q, nc_d;
  logic [1:0]  ph_q, ph_d;
  logic signed [31:0] trq_q, trq_d, vel_q, vel_d;
  logic [15:0] dt_q, dt_d;
  logic [31:0] acc_q, acc_d;
  logic [32:0] dvm_q, dvm_d;

  logic            div_start, div_done;
  logic [DvdW-1:0] dvd, quo;
  logic [DvsW-1:0] dvs;

  logic signed [33:0] y, x, diff, t34, tabs, res;
  logic [32:0] dmag, q33;
  logic [48:0] prod;
  logic        skip, gated, in_xfer, out_xfer, commit;
  logic [31:0] qsat;
  state_e      flt_next;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q     <= '0;
      min_acc_q <= '0;
      min_trq_q <= '0;
      lift_q    <= '0;
      td_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF:    cut_q     <= cfg_data_i[23:0];
        CFG_MIN_ACCEL: min_acc_q <= cfg_data_i;
        CFG_MIN_TRQ:   min_trq_q <= cfg_data_i;
        CFG_LIFTOFF:   lift_q    <= cfg_data_i;
        CFG_TOUCHDOWN: td_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter operands
  always_comb begin
    t34  = {{2{trq_q[31]}}, trq_q};
    tabs = t34[33] ? -t34 : t34;
    case (ph_q)
      2'd0: begin
        y = {{2{fv_q[31]}}, fv_q};
        x = {{2{vel_q[31]}}, vel_q};
      end
      2'd1: begin
        y = {2'b00, maa_q};
        x = {2'b00, acc_q};
      end
      default: begin
        y = {2'b00, mat_q};
        x = tabs;
      end
    endcase
    diff = x - y;
    dmag = diff[33] ? 33'(-diff) : diff[32:0];
    prod = dmag * dt_q;
    skip = {8'd0, dt_q} >= cut_q;
    q33  = quo[32:0];
    qsat = (|quo[DvdW-1:32]) ? '1 : quo[31:0];
    gated = !cont_q && ((maa_q < min_acc_q) || (mat_q < min_trq_q));
  end

  always_comb begin
    case (ph_q)
      2'd0:    flt_next = S_ACC_GO;
      2'd1:    flt_next = S_FLT_GO;
      default: flt_next = S_GATE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_xfer) state_d = (cut_q == '0) ? S_OUT : S_FLT_GO;
      S_FLT_GO:  state_d = skip ? flt_next : S_FLT_DIV;
      S_FLT_DIV: if (div_done) state_d = flt_next;
      S_ACC_GO:  state_d = S_ACC_DIV;
      S_ACC_DIV: if (div_done) state_d = S_FLT_GO;
      S_GATE:    state_d = gated ? S_OUT : S_INR_GO;
      S_INR_GO:  state_d = S_INR_DIV;
      S_INR_DIV: if (div_done) state_d = S_OUT;
      S_OUT:     if (out_o.ready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    div_start   = 1'b0;
    dvd         = {{(DvdW-49){1'b0}}, prod};
    dvs         = DvsW'(cut_q);
    case (state_q)
      S_IDLE:   in_i.ready = 1'b1;
      S_FLT_GO: div_start = !skip;
      S_ACC_GO: begin
        div_start = 1'b1;
        dvd       = DvdW'(dvm_q) * DvdW'(UsPerS);
        dvs       = DvsW'(dt_q);
      end
      S_INR_GO: begin
        div_start = 1'b1;
        dvd       = DvdW'(mat_q) << FracBits;
        dvs       = {1'b0, maa_q} + EpsQ;
      end
      S_ACC_DIV: begin
        dvd = DvdW'(dvm_q) * DvdW'(UsPerS);
        dvs = DvsW'(dt_q);
      end
      S_INR_DIV: begin
        dvd = DvdW'(mat_q) << FracBits;
        dvs = {1'b0, maa_q} + EpsQ;
      end
      S_OUT:    out_o.valid = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    fv_d  = fv_q;
    maa_d = maa_q;
    mat_d = mat_q;
    inr_d = inr_q;
    cont_d = cont_q;
    nc_d  = nc_q;
    ph_d  = ph_q;
    trq_d = trq_q;
    vel_d = vel_q;
    dt_d  = dt_q;
    acc_d = acc_q;
    dvm_d = dvm_q;
    commit = 1'b0;
    res   = x;
    if (state_q == S_IDLE && in_xfer) begin
      trq_d = in_i.torque_sample;
      vel_d = in_i.velocity_sample;
      dt_d  = (in_i.step_us == '0) ? 16'd1 : in_i.step_us;
      nc_d  = (cut_q == '0);
      ph_d  = 2'd0;
    end
    if (state_q == S_FLT_GO && skip) begin
      commit = 1'b1;
      res    = x;
      dvm_d  = dmag;
    end
    if (state_q == S_FLT_DIV && div_done) begin
      commit = 1'b1;
      res    = diff[33] ? (y - $signed({1'b0, q33})) : (y + $signed({1'b0, q33}));
      dvm_d  = q33;
    end
    if (commit) begin
      ph_d = ph_q + 2'd1;
      case (ph_q)
        2'd0:    fv_d  = res[31:0];
        2'd1:    maa_d = res[31:0];
        default: mat_d = res[31:0];
      endcase
      if (ph_q != 2'd0) begin
        dvm_d = dvm_q;
      end
    end
    if (state_q == S_ACC_DIV && div_done) begin
      acc_d = qsat;
    end
    if (state_q == S_INR_DIV && div_done) begin
      inr_d = qsat;
      if (qsat < lift_q) begin
        cont_d = 1'b0;
      end else if (qsat > td_q) begin
        cont_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fv_q    <= '0;
      maa_q   <= '0;
      mat_q   <= '0;
      inr_q   <= '0;
      cont_q  <= 1'b0;
      nc_q    <= 1'b0;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      fv_q    <= fv_d;
      maa_q   <= maa_d;
      mat_q   <= mat_d;
      inr_q   <= inr_d;
      cont_q  <= cont_d;
      nc_q    <= nc_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trq_q <= trq_d;
    vel_q <= vel_d;
    dt_q  <= dt_d;
    acc_q <= acc_d;
    dvm_q <= dvm_d;
  end

  wcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quo)
  );

  assign out_o.contact_out    = cont_q;
  assign out_o.inertia_out    = inr_q;
  assign out_o.not_configured = nc_q;

  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_FLT_DIV || state_q == S_ACC_DIV || state_q == S_INR_DIV))
    else $error("divider done outside a divide step");
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |=> state_q == S_IDLE) else $error("no return to idle after transfer");
  a_nc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && nc_q) |-> ($stable(fv_q) && $stable(maa_q) && $stable(mat_q)))
    else $error("state changed while unconfigured");

endmodule
`default_nettype wire

@@ tb/wcd_checker.sv @@
`timescale 1ns / 100ps
module wcd_checker import wcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] torque_i,
  input  wire logic [31:0] velocity_i,
  input  wire logic [15:0] step_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        contact_i,
  input  wire logic [31:0] inertia_i,
  input  wire logic        not_cfg_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic        contact;
    logic [31:0] inertia;
    logic        not_cfg;
  } wheel_result_t;

  localparam longint EpsQ = ((longint'(1) << FracBitsDef) + 5000) / 10000 == 0 ? 1 :
                            ((longint'(1) << FracBitsDef) + 5000) / 10000;
  localparam longint Sat = 64'hFFFF_FFFF;

  logic [23:0] cut_r;
  logic [31:0] min_acc_r, min_trq_r, lift_r, touch_r;
  logic [31:0] fvel_r, macc_r, mtrq_r, inr_r;
  logic        contact_r;
  wheel_result_t result_q[$];

  function automatic longint lowpass(longint y, longint x, longint dt, longint cut);
    if (dt >= cut) return x;
    return y + ((x - y) * dt) / cut;
  endfunction

  task automatic predict_sample(logic [31:0] trq, logic [31:0] vel, logic [15:0] step);
    longint dt, pv, nv, dv, acc, tm, q;
    wheel_result_t r;
    logic gated;
    if (cut_r == 0) begin
      r = '{contact_r, inr_r, 1'b1};
      result_q.push_back(r);
      return;
    end
    dt = (step == 0) ? 1 : longint'(step);
    pv = longint'($signed(fvel_r));
    nv = lowpass(pv, longint'($signed(vel)), dt, longint'(cut_r));
    fvel_r = nv[31:0];
    dv = nv - pv;
    if (dv < 0) dv = -dv;
    acc = dv * 1000000 / dt;
    if (acc > Sat) acc = Sat;
    macc_r = 32'(lowpass({32'd0, macc_r}, acc, dt, longint'(cut_r)));
    tm = longint'($signed(trq));
    if (tm < 0) tm = -tm;
    mtrq_r = 32'(lowpass({32'd0, mtrq_r}, tm, dt, longint'(cut_r)));
    gated = !contact_r && (macc_r < min_acc_r || mtrq_r < min_trq_r);
    if (!gated) begin
      q = (longint'({32'd0, mtrq_r}) << FracBitsDef) / (longint'({32'd0, macc_r}) + EpsQ);
      if (q > Sat) q = Sat;
      inr_r = q[31:0];
      if (inr_r < lift_r) contact_r = 1'b0;
      else if (inr_r > touch_r) contact_r = 1'b1;
    end
    r = '{contact_r, inr_r, 1'b0};
    result_q.push_back(r);
  endtask

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_result_t e;
    if (!rst_ni) begin
      cut_r = '0; min_acc_r = '0; min_trq_r = '0; lift_r = '0; touch_r = '0;
      fvel_r = '0; macc_r = '0; mtrq_r = '0; inr_r = '0; contact_r = 1'b0;
      fail_count_o = 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CUTOFF:    cut_r = cfg_data_i[23:0];
          CFG_MIN_ACCEL: min_acc_r = cfg_data_i;
          CFG_MIN_TRQ:   min_trq_r = cfg_data_i;
          CFG_LIFTOFF:   lift_r = cfg_data_i;
          CFG_TOUCHDOWN: touch_r = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result contact=%0b inertia=%h nc=%0b",
                   $time, contact_i, inertia_i, not_cfg_i);
          fail_count_o++;
        end else begin
          e = result_q.pop_front();
          if (e.contact !== contact_i) begin
            $display("%0t: contact exp %0b got %0b", $time, e.contact, contact_i);
            fail_count_o++;
          end
          if (e.inertia !== inertia_i) begin
            $display("%0t: inertia exp %h got %h", $time, e.inertia, inertia_i);
            fail_count_o++;
          end
          if (e.not_cfg !== not_cfg_i) begin
            $display("%0t: not_configured exp %0b got %0b", $time, e.not_cfg, not_cfg_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_sample(torque_i, velocity_i, step_i);
    end
  end

endmodule

@@ tb/tb_wheel_contact_detector.sv @@
`timescale 1ns / 100ps
module tb_wheel_contact_detector;
  import wcd_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending, idle_cycles;

  wcd_in_if  in_if();
  wcd_out_if out_if();

  always #4 clk_i = ~clk_i;

  wheel_contact_detector u_dut (
    .clk_i, .rst_ni, .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  wcd_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
    .torque_i(in_if.torque_sample), .velocity_i(in_if.velocity_sample),
    .step_i(in_if.step_us),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
    .contact_i(out_if.contact_out), .inertia_i(out_if.inertia_out),
    .not_cfg_i(out_if.not_configured),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.torque_sample = '0;
    in_if.velocity_sample = '0;
    in_if.step_us = 16'd1;
    out_if.ready = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
    return $urandom_range(0, 3);
  endfunction

  // sink side stalls
  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                                ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high after a transfer until the next gap or drain
  task automatic send_sample(logic [31:0] trq, logic [31:0] vel, logic [15:0] step);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.torque_sample <= trq;
    in_if.velocity_sample <= vel;
    in_if.step_us <= step;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [23:0] cut, logic [31:0] ma, logic [31:0] mt,
                            logic [31:0] lo, logic [31:0] hi);
    write_reg(CFG_CUTOFF, {8'd0, cut});
    write_reg(CFG_MIN_ACCEL, ma);
    write_reg(CFG_MIN_TRQ, mt);
    write_reg(CFG_LIFTOFF, lo);
    write_reg(CFG_TOUCHDOWN, hi);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [15:0] st;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: st = 16'($urandom());
        1: st = '0;
        default: st = 16'($urandom_range(1, 3000));
      endcase
      send_sample(rand_val($urandom_range(0, 3)), rand_val($urandom_range(0, 3)), st);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // unconfigured samples pass through with state held
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'd10);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    drain();
    set_config(24'd1000, 32'd0, 32'd0, 32'h0000_8000, 32'h0001_0000);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'd1);
    send_sample(32'h0001_0000, 32'h8000_0000, 16'hFFFF);
    send_sample(32'h0001_0000, 32'h7FFF_FFFF, 16'd0);
    send_sample(32'h0, 32'h0, 16'd500);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 16'd999);
    send_sample(32'h0010_0000, 32'h0, 16'd1000);
    send_sample(32'h0010_0000, 32'h0, 16'd1001);
    drain();
    // touchdown gate closed by large minimums
    set_config(24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h1234_5678, 16'hFFFF);
    send_sample(32'h8000_0001, 32'hEDCB_A988, 16'd1);
    send_sample(32'h0, 32'h0, 16'd0);
    drain();
    set_config(24'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_sample(32'h0000_0100, 32'h0000_0001, 16'd1);
    send_sample(32'h0000_0000, 32'h0000_0000, 16'd1);
    drain();
    set_config(24'd2000, 32'd100, 32'd100, 32'h0000_4000, 32'h0002_0000);
    random_phase(200);
    drain();
    set_config(24'd50, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 18),
               $urandom_range(0, 1 << 16), $urandom_range(1 << 16, 1 << 22));
    random_phase(200);
    drain();
    set_config(24'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    random_phase(150);
    drain();
    set_config(24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(30);
    drain();
    set_config(24'd10000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0);
    random_phase(200);
    drain();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
